[design/dynamic_priority_scheduler_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dynamic priority scheduler unit
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define DPSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpsu assertion failed");

// Property that must hold in the cycle after its antecedent.
`define DPSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpsu assertion failed");

`endif

[design/dpsu_pkg.sv]
// ----------------------------------------------------------------------------
// dpsu_pkg
// Shared constants, types and helpers of the dynamic priority scheduler.
// ----------------------------------------------------------------------------
package dpsu_pkg;

  // Queue geometry (valid range 2 .. 31).
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request function codes.
  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Lowest priority; aging saturates here.
  localparam logic [7:0] PRIO_MIN = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SCAN,
    ST_PLACE,
    ST_EMIT
  } state_e;

  // One ready-queue entry as stored in memory.
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] need;
    logic [15:0] used;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // One result item.
  typedef struct packed {
    logic        admitted;
    logic        overflow;
    logic        ran_valid;
    logic [7:0]  ran_id;
    logic [7:0]  ran_priority;
    logic [15:0] ran_elapsed;
    logic        finished;
    logic [4:0]  queue_count;
  } res_t;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
    return (p == '0) ? ADDR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [4:0] count_to_out(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[4:0];
  endfunction

endpackage

[design/dpsu_if.sv]
// ----------------------------------------------------------------------------
// dpsu_req_if / dpsu_res_if
// Valid/ready channels for scheduler requests and results.
// ----------------------------------------------------------------------------
interface dpsu_req_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic [7:0]        proc_id;
  logic signed [7:0] priority_req;
  logic [15:0]       run_time;

  modport source (output valid, func, proc_id, priority_req, run_time, input ready);
  modport sink   (input valid, func, proc_id, priority_req, run_time, output ready);
endinterface

interface dpsu_res_if;
  logic              valid;
  logic              ready;
  logic              admitted;
  logic              overflow;
  logic              ran_valid;
  logic [7:0]        ran_id;
  logic signed [7:0] ran_priority;
  logic [15:0]       ran_elapsed;
  logic              finished;
  logic [4:0]        queue_count;

  modport source (output valid, admitted, overflow, ran_valid, ran_id, ran_priority,
                  ran_elapsed, finished, queue_count, input ready);
  modport sink   (input valid, admitted, overflow, ran_valid, ran_id, ran_priority,
                  ran_elapsed, finished, queue_count, output ready);
endinterface

[design/dynamic_priority_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler_unit
// Priority scheduler with aging over a ready queue held in one memory.
// ----------------------------------------------------------------------------
// Admit: the result follows the shift pass over the queued entries of lower
//   priority (at most QUEUE_DEPTH - 1 of them).
// Tick: no pass on an empty queue or when the head finishes, else a reinsert pass.
// Throughput: one request at a time; the backward shift pass over the
//   single-read, single-write queue memory sets the rate (one entry/cycle).
// Reset: asynchronous, active low; empties the queue at once, no clear pass.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dpsu_req_if.sink   req_i,
  dpsu_res_if.source res_o
);
  import dpsu_pkg::*;

  // Queue memory ports.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  // Sequencer to output register.
  logic out_free;
  logic emit;
  res_t res;

  // Sequencer: pop the head on a tick, age and reinsert it if unfinished,
  // or insert an admitted request. Entries live in a circular buffer
  // between head and tail; insertion walks backward from the tail,
  // shifting each lower-priority entry one slot toward the tail until the
  // new entry's place is found, so equal priorities keep arrival order.
  dpsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Ready-queue storage. Entries outside head..tail are never read, so the
  // memory needs no clearing after reset.
  dpsu_ram #(
    .Depth (QUEUE_DEPTH),
    .Width (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold the finished result until the consumer takes it.
  dpsu_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (emit),
    .data_i (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

[design/dpsu_ram.sv]
// ----------------------------------------------------------------------------
// dpsu_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dpsu_ram #(
  parameter  int unsigned Depth = 16,
  parameter  int unsigned Width = 48,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/dpsu_ctrl.sv]
// ----------------------------------------------------------------------------
// dpsu_ctrl
// Sequencer of the ready queue: pops the head, runs it, and inserts entries
// by a backward shift pass over the circular buffer in memory.
// ----------------------------------------------------------------------------
module dpsu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dpsu_req_if.sink               req_i,
  input  logic                   out_free_i,
  output logic                   emit_o,
  output dpsu_pkg::res_t         res_o,
  output logic                   ram_we_o,
  output logic [dpsu_pkg::ADDR_W-1:0]  ram_waddr_o,
  output logic [dpsu_pkg::ENTRY_W-1:0] ram_wdata_o,
  output logic                   ram_re_o,
  output logic [dpsu_pkg::ADDR_W-1:0]  ram_raddr_o,
  input  logic [dpsu_pkg::ENTRY_W-1:0] ram_rdata_i
);
  import dpsu_pkg::*;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [ADDR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]  remain_q, remain_d;
  entry_t            ins_q, ins_d;
  res_t              res_q, res_d;

  entry_t            rd_entry;
  logic [15:0]       used_inc;
  logic [15:0]       need_fix;
  logic              accept;

  assign rd_entry = entry_t'(ram_rdata_i);
  assign used_inc = rd_entry.used + 16'd1;
  assign need_fix = (req_i.run_time == 16'd0) ? 16'd1 : req_i.run_time;
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    wr_ptr_d    = wr_ptr_q;
    remain_d    = remain_q;
    ins_d       = ins_q;
    res_d       = res_q;
    emit_o      = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wr_ptr_q;
    ram_wdata_o = ENTRY_W'(ins_q);
    ram_re_o    = 1'b0;
    ram_raddr_o = ptr_dec(tail_q);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          if (req_i.func == FUNC_ADMIT) begin
            if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              res_d.overflow = 1'b1;
              state_d        = ST_EMIT;
            end else begin
              res_d.admitted = 1'b1;
              ins_d.id   = req_i.proc_id;
              ins_d.prio = req_i.priority_req;
              ins_d.need = need_fix;
              ins_d.used = 16'd0;
              wr_ptr_d   = tail_q;
              remain_d   = count_q;
              tail_d     = ptr_inc(tail_q);
              count_d    = count_q + 1'b1;
              if (count_q == '0) begin
                state_d = ST_PLACE;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = ptr_dec(tail_q);
                state_d     = ST_SCAN;
              end
            end
          end else begin
            if (count_q == '0) begin
              state_d = ST_EMIT;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = head_q;
              state_d     = ST_HEAD;
            end
          end
        end
      end

      ST_HEAD: begin
        res_d.ran_valid    = 1'b1;
        res_d.ran_id       = rd_entry.id;
        res_d.ran_priority = rd_entry.prio;
        res_d.ran_elapsed  = used_inc;
        head_d             = ptr_inc(head_q);
        if (used_inc >= rd_entry.need) begin
          res_d.finished = 1'b1;
          count_d        = count_q - 1'b1;
          state_d        = ST_EMIT;
        end else begin
          ins_d.id   = rd_entry.id;
          ins_d.prio = (rd_entry.prio == PRIO_MIN) ? rd_entry.prio
                                                   : rd_entry.prio - 8'd1;
          ins_d.need = rd_entry.need;
          ins_d.used = used_inc;
          wr_ptr_d   = tail_q;
          remain_d   = count_q - 1'b1;
          tail_d     = ptr_inc(tail_q);
          if (count_q == CNT_W'(1)) begin
            state_d = ST_PLACE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = ptr_dec(tail_q);
            state_d     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        ram_we_o = 1'b1;
        if ($signed(rd_entry.prio) >= $signed(ins_q.prio)) begin
          state_d = ST_EMIT;
        end else begin
          // Shift the lower-priority entry one place toward the tail.
          ram_wdata_o = ram_rdata_i;
          wr_ptr_d    = ptr_dec(wr_ptr_q);
          remain_d    = remain_q - 1'b1;
          if (remain_q == CNT_W'(1)) begin
            state_d = ST_PLACE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = ptr_dec(ptr_dec(wr_ptr_q));
          end
        end
      end

      ST_PLACE: begin
        ram_we_o = 1'b1;
        state_d  = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o             = res_q;
    res_o.queue_count = count_to_out(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_ptr_q <= wr_ptr_d;
    remain_q <= remain_d;
    ins_q    <= ins_d;
    res_q    <= res_d;
  end

endmodule

[design/dpsu_out_reg.sv]
// ----------------------------------------------------------------------------
// dpsu_out_reg
// Result holding register; parts the sequencer from the result channel.
// ----------------------------------------------------------------------------
module dpsu_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  dpsu_pkg::res_t data_i,
  output logic           free_o,
  dpsu_res_if.source     res_o
);
  import dpsu_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.admitted     = data_q.admitted;
  assign res_o.overflow     = data_q.overflow;
  assign res_o.ran_valid    = data_q.ran_valid;
  assign res_o.ran_id       = data_q.ran_id;
  assign res_o.ran_priority = $signed(data_q.ran_priority);
  assign res_o.ran_elapsed  = data_q.ran_elapsed;
  assign res_o.finished     = data_q.finished;
  assign res_o.queue_count  = data_q.queue_count;

endmodule

[design/dpsu_checker.sv]
// ----------------------------------------------------------------------------
// dpsu_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "dynamic_priority_scheduler_unit_macros.svh"

module dpsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        admitted_i,
  input logic        overflow_i,
  input logic        ran_valid_i,
  input logic [7:0]  ran_id_i,
  input logic [15:0] ran_elapsed_i,
  input logic        finished_i,
  input logic [4:0]  queue_count_i
);
  import dpsu_pkg::*;

  // A stalled result holds.
  `DPSU_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(ran_id_i) && $stable(ran_elapsed_i) && $stable(queue_count_i))

  // One request at a time: the input closes right after a request is taken.
  `DPSU_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // Admit and run fields never mix in one result.
  `DPSU_ASSERT_SAME(a_kind_excl, clk_i, rst_ni, res_valid_i, !((admitted_i || overflow_i) && ran_valid_i) && !(admitted_i && overflow_i))

  // Finish only for a process that ran, overflow only when the queue is full.
  `DPSU_ASSERT_SAME(a_fin_ran, clk_i, rst_ni, res_valid_i && finished_i, ran_valid_i && ran_elapsed_i != 16'd0)
  `DPSU_ASSERT_SAME(a_ovf_full, clk_i, rst_ni, res_valid_i && overflow_i, queue_count_i == count_to_out(CNT_W'(QUEUE_DEPTH)))

endmodule

bind dynamic_priority_scheduler_unit dpsu_checker u_dpsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .admitted_i    (res_o.admitted),
  .overflow_i    (res_o.overflow),
  .ran_valid_i   (res_o.ran_valid),
  .ran_id_i      (res_o.ran_id),
  .ran_elapsed_i (res_o.ran_elapsed),
  .finished_i    (res_o.finished),
  .queue_count_i (res_o.queue_count)
);
